// ===== src/bec_pkg.sv =====
// Shared constants, codes and beat types for the backspace edit compare block.
`timescale 1ns / 1ps

package bec_pkg;

  // Stack geometry
  localparam int DEPTH  = 256;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  // Character class bounds: lowercase letters push, anything else pops
  localparam logic [7:0] LETTER_LO = 8'h61;
  localparam logic [7:0] LETTER_HI = 8'h7A;

  // Function selector codes
  localparam logic [1:0] FUNC_FIRST  = 2'd0;
  localparam logic [1:0] FUNC_SECOND = 2'd1;
  localparam logic [1:0] FUNC_FINISH = 2'd2;

  // Input beat
  typedef struct packed {
    logic [1:0] func;
    logic [7:0] ch;
  } in_beat_t;

  // Result beat
  typedef struct packed {
    logic equal;
    logic overflow;
  } out_beat_t;

  // Controller to datapath commands
  typedef struct packed {
    logic edit_first;
    logic edit_second;
    logic cmp_start;
    logic cmp_read;
    logic cmp_next;
    logic emit;
    logic emit_equal;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic len_equal;
    logic len_zero;
    logic idx_last;
    logic data_equal;
  } status_t;

endpackage

// ===== src/bec_ctrl.sv =====
// Controller state machine: accepts beats and sequences the stack compare.
`timescale 1ns / 1ps

module bec_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [1:0]      func,
  input  bec_pkg::status_t sts,
  output logic            busy,
  output bec_pkg::cmd_t   cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_READ  = 2'd1;
  localparam logic [1:0] ST_CHECK = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       accept;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start & ~busy;

  // Decode beats and walk the compare loop
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (func)
            bec_pkg::FUNC_FIRST:  cmd.edit_first  = 1'b1;
            bec_pkg::FUNC_SECOND: cmd.edit_second = 1'b1;
            bec_pkg::FUNC_FINISH: begin
              if (!sts.len_equal) begin
                cmd.emit       = 1'b1;
                cmd.emit_equal = 1'b0;
              end else if (sts.len_zero) begin
                cmd.emit       = 1'b1;
                cmd.emit_equal = 1'b1;
              end else begin
                cmd.cmp_start = 1'b1;
                state_nxt     = ST_READ;
              end
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        cmd.cmp_read = 1'b1;
        state_nxt    = ST_CHECK;
      end
      ST_CHECK: begin
        if (!sts.data_equal) begin
          cmd.emit       = 1'b1;
          cmd.emit_equal = 1'b0;
          state_nxt      = ST_IDLE;
        end else if (sts.idx_last) begin
          cmd.emit       = 1'b1;
          cmd.emit_equal = 1'b1;
          state_nxt      = ST_IDLE;
        end else begin
          cmd.cmp_next = 1'b1;
          state_nxt    = ST_READ;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== src/bec_dpath.sv =====
// Datapath: two character stacks, their counts, overflow flag and compare index.
`timescale 1ns / 1ps

module bec_dpath (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [7:0]          ch,
  input  bec_pkg::cmd_t       cmd,
  output bec_pkg::status_t    sts,
  output logic                out_valid,
  output bec_pkg::out_beat_t  out_data
);

  logic [7:0]                  first_mem_r  [bec_pkg::DEPTH];
  logic [7:0]                  second_mem_r [bec_pkg::DEPTH];
  logic [bec_pkg::CNT_W-1:0]   first_cnt_r,  first_cnt_nxt;
  logic [bec_pkg::CNT_W-1:0]   second_cnt_r, second_cnt_nxt;
  logic                        ovf_r,        ovf_nxt;
  logic [bec_pkg::ADDR_W-1:0]  idx_r,        idx_nxt;
  logic [7:0]                  first_rd_r;
  logic [7:0]                  second_rd_r;
  logic                        out_valid_r;
  bec_pkg::out_beat_t          out_data_r;
  logic                        is_letter;
  logic                        first_full;
  logic                        second_full;
  logic                        first_push;
  logic                        second_push;
  logic [bec_pkg::CNT_W-1:0]   last_pos;

  assign is_letter   = (ch >= bec_pkg::LETTER_LO) && (ch <= bec_pkg::LETTER_HI);
  assign first_full  = (first_cnt_r  == bec_pkg::CNT_W'(bec_pkg::DEPTH));
  assign second_full = (second_cnt_r == bec_pkg::CNT_W'(bec_pkg::DEPTH));
  assign first_push  = cmd.edit_first  & is_letter & ~first_full;
  assign second_push = cmd.edit_second & is_letter & ~second_full;
  assign last_pos    = first_cnt_r - bec_pkg::CNT_W'(1);

  // Report status to the controller
  assign sts.len_equal  = (first_cnt_r == second_cnt_r);
  assign sts.len_zero   = (first_cnt_r == '0);
  assign sts.idx_last   = (bec_pkg::CNT_W'(idx_r) == last_pos);
  assign sts.data_equal = (first_rd_r == second_rd_r);

  // Update counts, overflow flag and compare index
  always_comb begin
    first_cnt_nxt  = first_cnt_r;
    second_cnt_nxt = second_cnt_r;
    ovf_nxt        = ovf_r;
    idx_nxt        = idx_r;
    if (cmd.edit_first) begin
      if (is_letter) begin
        if (first_full) ovf_nxt = 1'b1;
        else first_cnt_nxt = first_cnt_r + bec_pkg::CNT_W'(1);
      end else if (first_cnt_r != '0) begin
        first_cnt_nxt = first_cnt_r - bec_pkg::CNT_W'(1);
      end
    end
    if (cmd.edit_second) begin
      if (is_letter) begin
        if (second_full) ovf_nxt = 1'b1;
        else second_cnt_nxt = second_cnt_r + bec_pkg::CNT_W'(1);
      end else if (second_cnt_r != '0) begin
        second_cnt_nxt = second_cnt_r - bec_pkg::CNT_W'(1);
      end
    end
    if (cmd.cmp_start) idx_nxt = '0;
    if (cmd.cmp_next)  idx_nxt = idx_r + bec_pkg::ADDR_W'(1);
    if (cmd.emit) begin
      first_cnt_nxt  = '0;
      second_cnt_nxt = '0;
      ovf_nxt        = 1'b0;
    end
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_cnt_r  <= '0;
      second_cnt_r <= '0;
      ovf_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      first_cnt_r  <= first_cnt_nxt;
      second_cnt_r <= second_cnt_nxt;
      ovf_r        <= ovf_nxt;
      out_valid_r  <= cmd.emit;
    end
  end

  // Advance compare index and capture the result beat
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (cmd.emit) begin
      out_data_r.equal    <= cmd.emit_equal;
      out_data_r.overflow <= ovf_r;
    end
  end

  // Push into the stacks
  always_ff @(posedge clk) begin
    if (first_push) begin
      first_mem_r[first_cnt_r[bec_pkg::ADDR_W-1:0]] <= ch;
    end
    if (second_push) begin
      second_mem_r[second_cnt_r[bec_pkg::ADDR_W-1:0]] <= ch;
    end
  end

  // Read both stacks at the compare index
  always_ff @(posedge clk) begin
    if (cmd.cmp_read) begin
      first_rd_r  <= first_mem_r[idx_r];
      second_rd_r <= second_mem_r[idx_r];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== src/backspace_edit_compare.sv =====
// Top level: edits two strings with backspaces and compares them on finish.
//
//   channel | ports                        | handshake
//   --------+------------------------------+-------------------------------
//   input   | start, busy, in_data         | beat taken when start & !busy
//   result  | out_valid, out_data          | one-cycle strobe, no stall
//
// A character beat (first or second string) never leaves idle; busy stays low.
// A finish beat decides straight from idle when the lengths differ or both are
// empty; otherwise it walks the stacks entry by entry, each entry passing
// through READ (registered memory read), then CHECK (compare).
// The result strobe rises in the cycle after the deciding step.
// Reset clears counts, overflow flag and strobe; stack contents need no clear.
`timescale 1ns / 1ps

module backspace_edit_compare_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  bec_pkg::in_beat_t   in_data,
  output logic                out_valid,
  output bec_pkg::out_beat_t  out_data
);

  bec_pkg::cmd_t    cmd;
  bec_pkg::status_t sts;

  bec_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .func  (in_data.func),
    .sts   (sts),
    .busy  (busy),
    .cmd   (cmd)
  );

  bec_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .ch        (in_data.ch),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
